>>> hdl/ipd_pkg.sv
// Shared types, constants and codes of the +IPD frame deframer.
package ipd_pkg;

    // Defaults for the top-level parameters
    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int MAX_DIGITS_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Fixed field and state widths
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 16;
    localparam int LEN_W   = 14;
    localparam int WIN_W   = 56;
    localparam int IPD_W   = 40;

    localparam logic [LEN_W-1:0]   LEN_MAX   = 14'd16383;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

    // Match patterns, newest byte in the low bits
    localparam logic [IPD_W-1:0] PAT_IPD   = 40'h2B4950442C;     // "+IPD,"
    localparam logic [WIN_W-1:0] PAT_ERROR = 56'h4552524F520D0A; // "ERROR\r\n"

    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    // Result kind codes
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END_OK  = 2'd1;
    localparam logic [1:0] KIND_END_ERR = 2'd2;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_DIGITS,
        MODE_PAYLOAD
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              timed_out;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [TOTAL_W-1:0] total_bytes;
        logic               last;
    } out_beat_t;

    // Queue entry: what the back end has to do
    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
    } op_t;

    // Read side of the queue as seen by the back end
    typedef struct packed {
        logic avail;
        op_t  op;
    } q_rd_t;

endpackage

>>> hdl/ipd_fifo.sv
// Small operation queue between the deframer front and back ends.
module ipd_fifo
    import ipd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  op_t   push_op,
    output logic  full,
    input  logic  pop,
    output q_rd_t rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign full     = (count_reg == CNT_FULL);
    assign rd.avail = (count_reg != '0);
    assign rd.op    = mem_reg[rd_ptr_reg];

endmodule

>>> hdl/ipd_front.sv
// Front end: byte classification, header/error hunt, length parse, payload count.
module ipd_front
    import ipd_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_beat_t beat,
    output logic     push,
    output op_t      push_op
);

    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam int DC_W   = $clog2(MAX_DIGITS + 1);
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(BUFFER_BYTES);
    localparam logic [DC_W-1:0]   DC_LIMIT   = DC_W'(MAX_DIGITS);

    typedef enum logic [1:0] {
        EVT_NONE,
        EVT_PAYLOAD,
        EVT_END_OK,
        EVT_END_ERR
    } evt_t;

    mode_t             mode_reg,   mode_next;
    logic [WIN_W-1:0]  win_reg,    win_next;
    logic [LEN_W-1:0]  rem_reg,    rem_next;
    logic [DC_W-1:0]   dc_reg,     dc_next;
    logic [LEN_W-1:0]  acc_reg,    acc_next;
    logic [FILL_W-1:0] fill_reg,   fill_next;
    evt_t              evt;

    logic [BYTE_W-1:0] b;
    logic              go_pay;
    logic              go_hunt;
    logic [LEN_W-1:0]  pay_rem;
    logic [WIN_W-1:0]  hunt_win;
    logic [FILL_W-1:0] hunt_fill;
    logic [WIN_W-1:0]  win_shift;
    logic [FILL_W-1:0] fill_inc;
    logic [LEN_W+3:0]  mul10;
    logic              is_digit;
    logic              buf_full;
    logic              owed;

    assign b        = beat.rx_byte;
    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign buf_full = (fill_reg >= FILL_LIMIT);
    assign owed     = (mode_reg == MODE_PAYLOAD) && (rem_reg != '0);
    assign mul10    = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                    + {{LEN_W{1'b0}}, b[3:0]};

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        win_next  = win_reg;
        rem_next  = rem_reg;
        dc_next   = dc_reg;
        acc_next  = acc_reg;
        fill_next = fill_reg;
        evt       = EVT_NONE;
        go_pay    = 1'b0;
        go_hunt   = 1'b0;
        pay_rem   = rem_reg;
        hunt_win  = win_reg;
        hunt_fill = fill_reg;
        win_shift = '0;
        fill_inc  = '0;

        if (accept)
        begin
            if (buf_full)
            begin
                evt = owed ? EVT_END_ERR : EVT_END_OK;
            end
            else if (beat.timed_out)
            begin
                evt = (owed || (mode_reg == MODE_DIGITS)) ? EVT_END_ERR : EVT_END_OK;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_DIGITS:
                    begin
                        if (b == CHAR_COLON)
                        begin
                            mode_next = MODE_PAYLOAD;
                            rem_next  = acc_reg;
                        end
                        else if (dc_reg >= DC_LIMIT)
                        begin
                            go_pay  = 1'b1;
                            pay_rem = acc_reg;
                        end
                        else if (is_digit)
                        begin
                            acc_next = (mul10 > {4'd0, LEN_MAX}) ? LEN_MAX
                                                                 : mul10[LEN_W-1:0];
                            dc_next  = dc_reg + DC_W'(1);
                        end
                        else
                        begin
                            mode_next = MODE_PAYLOAD;
                            rem_next  = acc_reg;
                        end
                    end
                    MODE_PAYLOAD:
                    begin
                        go_pay = 1'b1;
                    end
                    MODE_HUNT:
                    begin
                        go_hunt = 1'b1;
                    end
                    default:
                    begin
                        go_hunt = 1'b1;
                    end
                endcase

                if (go_pay)
                begin
                    if (pay_rem == '0)
                    begin
                        // frame done: this byte starts a fresh hunt
                        go_hunt   = 1'b1;
                        hunt_win  = '0;
                        hunt_fill = '0;
                        mode_next = MODE_HUNT;
                    end
                    else
                    begin
                        mode_next = MODE_PAYLOAD;
                        rem_next  = pay_rem - LEN_W'(1);
                        fill_next = fill_reg + FILL_W'(1);
                        evt       = EVT_PAYLOAD;
                    end
                end

                if (go_hunt)
                begin
                    win_shift = {hunt_win[WIN_W-BYTE_W-1:0], b};
                    fill_inc  = hunt_fill + FILL_W'(1);
                    mode_next = MODE_HUNT;
                    win_next  = win_shift;
                    fill_next = fill_inc;
                    if (fill_inc >= FILL_LIMIT)
                    begin
                        evt = EVT_END_OK;
                    end
                    else if (win_shift[IPD_W-1:0] == PAT_IPD)
                    begin
                        mode_next = MODE_DIGITS;
                        dc_next   = '0;
                        acc_next  = '0;
                        win_next  = '0;
                    end
                    else if (win_shift == PAT_ERROR)
                    begin
                        evt = EVT_END_ERR;
                    end
                end
            end

            if ((evt == EVT_END_OK) || (evt == EVT_END_ERR))
            begin
                mode_next = MODE_HUNT;
                win_next  = '0;
                rem_next  = '0;
                dc_next   = '0;
                acc_next  = '0;
                fill_next = '0;
            end
        end
    end

    // Outputs
    always_comb
    begin
        push_op.data = b;
        unique case (evt)
            EVT_NONE:
            begin
                push         = 1'b0;
                push_op.kind = KIND_PAYLOAD;
            end
            EVT_PAYLOAD:
            begin
                push         = 1'b1;
                push_op.kind = KIND_PAYLOAD;
            end
            EVT_END_OK:
            begin
                push         = 1'b1;
                push_op.kind = KIND_END_OK;
            end
            EVT_END_ERR:
            begin
                push         = 1'b1;
                push_op.kind = KIND_END_ERR;
            end
            default:
            begin
                push         = 1'b0;
                push_op.kind = KIND_PAYLOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HUNT;
            win_reg  <= '0;
            rem_reg  <= '0;
            dc_reg   <= '0;
            acc_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            win_reg  <= win_next;
            rem_reg  <= rem_next;
            dc_reg   <= dc_next;
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
        end
    end

endmodule

>>> hdl/ipd_back.sv
// Back end: running payload total and the registered result beat.
module ipd_back
    import ipd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_rd_t     rd,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    logic               valid_reg, valid_next;
    out_beat_t          data_reg,  data_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] total_inc;

    assign pop       = rd.avail && (!valid_reg || !out_stall);
    assign total_inc = (total_reg == TOTAL_MAX) ? total_reg : total_reg + TOTAL_W'(1);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        total_next = total_reg;
        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        if (pop)
        begin
            valid_next        = 1'b1;
            data_next.kind    = rd.op.kind;
            if (rd.op.kind == KIND_PAYLOAD)
            begin
                total_next             = total_inc;
                data_next.payload_byte = rd.op.data;
                data_next.total_bytes  = total_inc;
                data_next.last         = 1'b0;
            end
            else
            begin
                // end of transfer: report total, start over
                total_next             = '0;
                data_next.payload_byte = '0;
                data_next.total_bytes  = total_reg;
                data_next.last         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/ipd_frame_deframer.sv
// Top level of the +IPD frame deframer: front end, operation queue, back end.
//
// Takes one received modem byte (or a timeout marker) per input beat and
// pulls payload out of frames "+IPD,<len>:<data>". Outside a frame the last
// seven bytes are watched for "+IPD," (frame start) and "ERROR\r\n" (transfer
// fails). Up to MAX_DIGITS decimal digits give the length, ended by ':' (which
// is consumed); that many bytes then leave as payload beats. A transfer ends
// on a timeout, on BUFFER_BYTES bytes counted (hunted plus payload), or on
// ERROR, with an end beat (last = 1) that carries the payload total,
// saturating at 65535; everything then returns to its reset state. Rate: one
// input beat per clock while in_stall is low. The front end makes every
// decision for a byte combinationally from its own state; results go through
// a queue of QUEUE_DEPTH entries to a registered output stage, and in_stall
// rises only once the queue has filled behind a stalled output.
module ipd_frame_deframer
    import ipd_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    logic  accept;
    logic  q_push;
    op_t   q_push_op;
    logic  q_full;
    logic  q_pop;
    q_rd_t q_rd;

    // no input beat while the queue has no room for its result
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    ipd_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .beat    (in_data),
        .push    (q_push),
        .push_op (q_push_op)
    );

    ipd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .rd      (q_rd)
    );

    ipd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (q_rd),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // queue is never written while full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("queue overflow");

    // pop only from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_rd.avail)
        else $error("queue underflow");

    // end beats and only end beats carry last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.kind != KIND_PAYLOAD)))
        else $error("last flag does not match kind");

    // a payload beat always counts itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.kind == KIND_PAYLOAD)) |-> (out_data.total_bytes != '0))
        else $error("payload beat with zero total");
`endif

endmodule
